// ----- rtl/core/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types, widths and the segment table of the seven-segment scan driver
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int VALUE_W     = 16;
	localparam int BASE_W      = 5;
	localparam int SEG_W       = 8;
	localparam int DIGIT_COUNT = 4;
	localparam int DIGIT_W     = 4;
	localparam int POS_W       = 2;
	localparam int STEP_W      = 4;

	localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
	localparam logic [BASE_W-1:0] BASE_RESET = 5'd16;

	// last division pass, its quotient is the top digit
	localparam logic [POS_W-1:0] LAST_PASS = 2'(DIGIT_COUNT - 2);
	localparam logic [POS_W-1:0] TOP_POS   = 2'(DIGIT_COUNT - 1);
	localparam logic [DIGIT_W-1:0] DIGIT_SAT = 4'hf;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} ssd_state_t;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [SEG_W-1:0] seg_t;
	typedef logic [DIGIT_COUNT-1:0] dig_en_t;

	// common-anode hex pattern, active low
	function automatic seg_t seg_lookup(input logic [DIGIT_W-1:0] digit);
		seg_t seg;
		case (digit)
			4'h0: seg = 8'hc0;
			4'h1: seg = 8'hf9;
			4'h2: seg = 8'ha4;
			4'h3: seg = 8'hb0;
			4'h4: seg = 8'h99;
			4'h5: seg = 8'h92;
			4'h6: seg = 8'h82;
			4'h7: seg = 8'hf8;
			4'h8: seg = 8'h80;
			4'h9: seg = 8'h90;
			4'ha: seg = 8'h88;
			4'hb: seg = 8'h83;
			4'hc: seg = 8'hc6;
			4'hd: seg = 8'ha1;
			4'he: seg = 8'h86;
			4'hf: seg = 8'h8e;
			default: seg = 8'hff;
		endcase
		return seg;
	endfunction

endpackage

// ----- rtl/core/ssd_value_if.sv -----
// ----------------------------------------------------------------------------
// ssd_value_if
// request channel carrying the value to display on each refresh tick
// ----------------------------------------------------------------------------
interface ssd_value_if;
	logic            valid;
	logic            ready;
	ssd_pkg::value_t display_value;

	modport source (output valid, output display_value, input ready);
	modport sink (input valid, input display_value, output ready);
endinterface

// ----- rtl/core/ssd_disp_if.sv -----
// ----------------------------------------------------------------------------
// ssd_disp_if
// result channel carrying segments, digit enable and overflow
// ----------------------------------------------------------------------------
interface ssd_disp_if;
	logic             valid;
	logic             ready;
	ssd_pkg::seg_t    segment_pattern;
	ssd_pkg::dig_en_t digit_enable;
	logic             overflow;

	modport source (output valid, output segment_pattern, output digit_enable,
		output overflow, input ready);
	modport sink (input valid, input segment_pattern, input digit_enable,
		input overflow, output ready);
endinterface

// ----- rtl/core/seven_segment_scan_driver.sv -----
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// four-digit multiplexed seven-segment driver with configurable number base
// ----------------------------------------------------------------------------
//
//  channel    dir   handshake      content
//  value_ch   in    valid/ready    display_value[15:0]
//  disp_ch    out   valid/ready    segment_pattern[7:0], digit_enable[3:0], overflow
//  cfg        in    cfg_we         cfg_wdata[4:0] = digit_base
//
// each request passes through the accept cycle, the shared restoring divider
// (three divisions by the base, one quotient bit per cycle) and the load of
// the output register
// reset clears the scan pointer, the sequencer and the output valid; the base
// returns to 16
// a stalled result waits in the output register while the next request is
// taken; the sequencer only stalls when a new result finds that register full
//
module seven_segment_scan_driver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ssd_pkg::BASE_W-1:0]  cfg_wdata,
	ssd_value_if.sink                   value_ch,
	ssd_disp_if.source                  disp_ch
);
	import ssd_pkg::*;

	// control state
	ssd_state_t          state_q, state_d;
	logic [BASE_W-1:0]   base_cfg_q;
	logic [BASE_W-1:0]   base_q;
	logic [STEP_W-1:0]   step_q;
	logic [POS_W-1:0]    pass_q;
	logic [POS_W-1:0]    scan_q;
	logic [POS_W-1:0]    pos_q;
	logic                out_valid_q;

	// divider datapath: remainder and dividend/quotient shift register
	logic [BASE_W-1:0]   rem_q;
	value_t              quo_q;
	logic [DIGIT_W-1:0]  digit_q;
	logic                ovf_q;

	// output register payload
	seg_t                seg_out_q;
	dig_en_t             en_out_q;
	logic                ovf_out_q;

	logic [BASE_W:0]     rem_shift;
	logic                quo_bit;
	logic [BASE_W:0]     rem_diff;
	logic [BASE_W-1:0]   rem_next;
	value_t              quo_next;
	logic                last_step;
	logic                last_pass;
	logic                rest_ovf;
	logic                in_take;
	logic                out_load;
	logic [BASE_W-1:0]   base_eff;

	// clamp the configured base into 2..16
	always_comb begin
		if (base_cfg_q < BASE_MIN) begin
			base_eff = BASE_MIN;
		end else if (base_cfg_q > BASE_MAX) begin
			base_eff = BASE_MAX;
		end else begin
			base_eff = base_cfg_q;
		end
	end

	// one restoring division step: shift in the next dividend bit,
	// subtract the base when it fits
	always_comb begin
		rem_shift = {rem_q, quo_q[VALUE_W-1]};
		quo_bit   = rem_shift >= {1'b0, base_q};
		rem_diff  = rem_shift - {1'b0, base_q};
		rem_next  = quo_bit ? rem_diff[BASE_W-1:0] : rem_shift[BASE_W-1:0];
		quo_next  = {quo_q[VALUE_W-2:0], quo_bit};
		last_step = step_q == '1;
		last_pass = pass_q == LAST_PASS;
		// what is left after three divisions must fit in one digit
		rest_ovf  = quo_next >= VALUE_W'(base_q);
	end

	// sequencer: next state and handshake strobes
	always_comb begin
		state_d        = state_q;
		in_take        = 1'b0;
		out_load       = 1'b0;
		value_ch.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				value_ch.ready = 1'b1;
				if (value_ch.valid) begin
					in_take = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (last_step && last_pass) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// output register free or being drained this cycle
				if (!out_valid_q || disp_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_cfg_q  <= BASE_RESET;
			step_q      <= '0;
			pass_q      <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				base_cfg_q <= cfg_wdata;
			end
			if (in_take) begin
				step_q <= '0;
				pass_q <= '0;
				scan_q <= scan_q + 2'd1;
			end else if (state_q == ST_DIV) begin
				step_q <= step_q + 4'd1;
				if (last_step) begin
					pass_q <= pass_q + 2'd1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (disp_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			base_q <= base_eff;
			pos_q  <= scan_q;
			rem_q  <= '0;
			quo_q  <= value_ch.display_value;
		end else if (state_q == ST_DIV) begin
			quo_q <= quo_next;
			// next pass divides the quotient, starting from a clear remainder
			rem_q <= last_step ? '0 : rem_next;
			if (last_step) begin
				if (pos_q == pass_q) begin
					digit_q <= rem_next[DIGIT_W-1:0];
				end
				if (last_pass) begin
					ovf_q <= rest_ovf;
					if (pos_q == TOP_POS) begin
						digit_q <= rest_ovf ? DIGIT_SAT : quo_next[DIGIT_W-1:0];
					end
				end
			end
		end
		if (out_load) begin
			seg_out_q <= seg_lookup(digit_q);
			en_out_q  <= dig_en_t'(1) << pos_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign disp_ch.valid           = out_valid_q;
	assign disp_ch.segment_pattern = seg_out_q;
	assign disp_ch.digit_enable    = en_out_q;
	assign disp_ch.overflow        = ovf_out_q;

	// the digit enable names exactly one digit
	a_onehot_en: assert property (@(posedge clk) disable iff (!arst_n)
		disp_ch.valid |-> $onehot(disp_ch.digit_enable))
		else $error("digit enable not one-hot");

	// the divider remainder always stays below the base
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < base_q)
		else $error("divider remainder out of range");

	// the block is busy for the cycle after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		value_ch.valid && value_ch.ready |=> !value_ch.ready)
		else $error("request taken while dividing");

	// an overflowing top digit shows F
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		disp_ch.valid && disp_ch.overflow && disp_ch.digit_enable[TOP_POS]
		|-> disp_ch.segment_pattern == seg_lookup(DIGIT_SAT))
		else $error("overflowed top digit not saturated");

endmodule

// ----- dv/ssd_scan_checker.sv -----
// ----------------------------------------------------------------------------
// ssd_scan_checker
// watches the value and display channels, predicts the scanned digit of each
// request and compares every display result against the prediction
// ----------------------------------------------------------------------------
module ssd_scan_checker import ssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BASE_W-1:0] cfg_wdata,
	ssd_value_if              value_mon,
	ssd_disp_if               disp_mon,
	output int                fail_count,
	output int                pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_MAX = 10;

	// hex digit glyphs, common anode, digit 0 in the low byte
	localparam logic [16*SEG_W-1:0] HEX_GLYPHS = {
		8'h8e, 8'h86, 8'ha1, 8'hc6, 8'h83, 8'h88, 8'h90, 8'h80,
		8'hf8, 8'h82, 8'h92, 8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0
	};

	typedef struct packed {
		seg_t    segs;
		dig_en_t enable;
		logic    ovf;
	} disp_word_t;

	logic [BASE_W-1:0] base_copy;
	logic [POS_W-1:0]  scan_copy;
	disp_word_t        expected_digits[$];

	function automatic disp_word_t predict_scan_digit(input value_t value,
		input logic [BASE_W-1:0] base_reg, input logic [POS_W-1:0] pos);
		int unsigned        radix;
		int unsigned        rest;
		int                 k;
		logic [DIGIT_W-1:0] digits [DIGIT_COUNT];
		disp_word_t         w;
		radix = base_reg;
		// out-of-range bases clamp to 2 and 16
		if (radix < 2) radix = 2;
		if (radix > 16) radix = 16;
		rest = value;
		for (k = 0; k < DIGIT_COUNT - 1; k++) begin
			digits[k] = DIGIT_W'(rest % radix);
			rest = rest / radix;
		end
		// top digit saturates to F when the value needs a fifth digit
		w.ovf = (rest >= radix);
		digits[DIGIT_COUNT-1] = w.ovf ? 4'hf : DIGIT_W'(rest);
		w.segs = HEX_GLYPHS[int'(digits[pos])*SEG_W +: SEG_W];
		w.enable = dig_en_t'(1) << pos;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		disp_word_t want;
		if (!arst_n) begin
			base_copy = BASE_RESET;
			scan_copy = '0;
			expected_digits.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			// result side first so a request cannot match in its own cycle
			if (disp_mon.valid && disp_mon.ready) begin
				if (expected_digits.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("%0t: unexpected display result seg %h en %b ovf %b",
							$realtime, disp_mon.segment_pattern, disp_mon.digit_enable,
							disp_mon.overflow);
					fail_count++;
				end else begin
					want = expected_digits.pop_front();
					if (disp_mon.segment_pattern !== want.segs ||
						disp_mon.digit_enable !== want.enable ||
						disp_mon.overflow !== want.ovf) begin
						if (fail_count < REPORT_MAX)
							$display("%0t: mismatch seg exp %h got %h, en exp %b got %b, ovf exp %b got %b",
								$realtime, want.segs, disp_mon.segment_pattern, want.enable,
								disp_mon.digit_enable, want.ovf, disp_mon.overflow);
						fail_count++;
					end
				end
			end
			if (value_mon.valid && value_mon.ready) begin
				expected_digits.push_back(predict_scan_digit(value_mon.display_value,
					base_copy, scan_copy));
				scan_copy = scan_copy + 1'b1;
			end
			if (cfg_we)
				base_copy = cfg_wdata;
			pending_count = expected_digits.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives refresh requests and base changes into the scan driver, with random
// idling on both channels; the scan checker beside the block predicts and
// compares every result, this module only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ssd_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 450;
	localparam int END_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 1000000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [BASE_W-1:0] cfg_wdata = BASE_RESET;
	int                fail_count;
	int                pending_count;
	int                cycle_count = 0;
	// sender runs back to back during some phases
	logic              quiet_sender = 1'b0;

	ssd_value_if value_ch ();
	ssd_disp_if  disp_ch ();

	seven_segment_scan_driver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value_ch  (value_ch),
		.disp_ch   (disp_ch)
	);

	ssd_scan_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.value_mon     (value_ch),
		.disp_mon      (disp_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #CLK_HALF clk = ~clk;

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// idle length: mostly a few cycles, now and then long enough to cover
	// a whole division pass
	function automatic int idle_span();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return $urandom_range(1, 3);
		else if (pick < 9)
			return $urandom_range(4, 12);
		return $urandom_range(20, 120);
	endfunction

	// one request on the value channel; valid stays high if the next request
	// follows without a gap
	task automatic send_value(input value_t value);
		int gap;
		gap = (quiet_sender || $urandom_range(0, 1) == 0) ? 0 : idle_span();
		if (gap > 0) begin
			value_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		value_ch.valid <= 1'b1;
		value_ch.display_value <= value;
		do @(posedge clk); while (!value_ch.ready);
		@(negedge clk);
	endtask

	// sender holds off until every request has come back
	task automatic wait_drained();
		value_ch.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// base register only changes while the block is idle
	task automatic program_base(input int base);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= BASE_W'(base);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls, with stretches of steady ready
	initial begin
		int stall_left;
		int steady_left;
		int pick;
		disp_ch.ready = 1'b0;
		stall_left = 0;
		steady_left = 0;
		forever begin
			@(negedge clk);
			if (steady_left > 0) begin
				disp_ch.ready <= 1'b1;
				steady_left--;
			end else if (stall_left > 0) begin
				disp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				disp_ch.ready <= 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 3)
					steady_left = $urandom_range(100, 400);
				else if (pick < 30)
					stall_left = idle_span();
			end
		end
	end

	initial begin
		int     items_left;
		int     phase_len;
		int     base;
		int     radix;
		int     span;
		value_t value;

		value_ch.valid = 1'b0;
		value_ch.display_value = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: four requests per base so each one covers every scan slot
		// reset base 16, all-zero and all-one values
		send_value(16'h0000);
		send_value(16'hffff);
		send_value(16'h0123);
		send_value(16'hcdef);
		// base 2, top slot shows a saturated digit on 16
		program_base(2);
		send_value(16'd0);
		send_value(16'd15);
		send_value(16'hffff);
		send_value(16'd16);
		// base 10, largest four-digit value and first overflow
		program_base(10);
		send_value(16'd0);
		send_value(16'd9999);
		send_value(16'd65535);
		send_value(16'd10000);
		// base below range, acts as base 2
		program_base(0);
		send_value(16'd1);
		send_value(16'd2);
		send_value(16'd4);
		send_value(16'd8);
		program_base(1);
		send_value(16'd17);
		send_value(16'd17);
		send_value(16'd17);
		send_value(16'd17);
		// base above range, acts as base 16
		program_base(31);
		send_value(16'hf00f);
		send_value(16'h0f0f);
		send_value(16'h8000);
		send_value(16'h7fff);

		// random phases, each with its own base
		items_left = RANDOM_ITEMS;
		while (items_left > 0) begin
			pick_base: begin
				case ($urandom_range(0, 9))
					0: base = $urandom_range(0, 1);
					1: base = $urandom_range(17, 31);
					default: base = $urandom_range(2, 16);
				endcase
			end
			program_base(base);
			radix = (base < 2) ? 2 : (base > 16) ? 16 : base;
			span = radix * radix * radix * radix;
			if (span > 65536)
				span = 65536;
			quiet_sender <= ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(15, 60);
			if (phase_len > items_left)
				phase_len = items_left;
			repeat (phase_len) begin
				case ($urandom_range(0, 9))
					0, 1: value = value_t'($urandom_range(0, 65535));
					// around the overflow edge
					2: value = value_t'((span - 1) + $urandom_range(0, (span < 65536) ? 1 : 0));
					3: value = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
					default: value = value_t'($urandom_range(0, span - 1));
				endcase
				send_value(value);
				// occasional full drain in the middle of a phase
				if ($urandom_range(0, 49) == 0)
					wait_drained();
			end
			items_left -= phase_len;
		end

		wait_drained();
		repeat (END_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ssd_pkg.sv
rtl/core/ssd_value_if.sv
rtl/core/ssd_disp_if.sv
rtl/core/seven_segment_scan_driver.sv
dv/ssd_scan_checker.sv
dv/tb_top.sv
